[rtl/core/pte_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pte_pkg;

    // Result kinds
    localparam logic [2:0] EV_KEY   = 3'd0;
    localparam logic [2:0] EV_VALUE = 3'd1;
    localparam logic [2:0] EV_DROP  = 3'd2;
    localparam logic [2:0] EV_HDR   = 3'd3;
    localparam logic [2:0] EV_TRUNC = 3'd4;
    localparam logic [2:0] EV_IEND  = 3'd5;

    // Chunk type codes, big-endian ASCII
    localparam logic [31:0] TYPE_IEND = 32'h49454E44;
    localparam logic [31:0] TYPE_TEXT = 32'h74455874;

    // Bytes of CRC trailing every chunk payload
    localparam logic [32:0] PTE_CRC_BYTES = 33'd4;

    // Default depth of the queue between parser and output stage
    localparam int PTE_QUEUE_DEPTH = 4;

    // Everything one input byte produces: one or two results
    typedef struct packed {
        logic [2:0] kind0;
        logic [7:0] byte0;
        logic       end0;
        logic       two;
        logic [2:0] kind1;
    } t_evt_rec;

    // Expected PNG signature byte at a given position
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0: v = 8'd137;
            3'd1: v = 8'd80;
            3'd2: v = 8'd78;
            3'd3: v = 8'd71;
            3'd4: v = 8'd13;
            3'd5: v = 8'd10;
            3'd6: v = 8'd26;
            3'd7: v = 8'd10;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/pte_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module pte_front
    import pte_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_stream_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_final_byte,
    output logic            o_push,
    output t_evt_rec        o_rec
);

    // Parser phases
    localparam logic [2:0] PH_SIG   = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_TYPE  = 3'd2;
    localparam logic [2:0] PH_KEY   = 3'd3;
    localparam logic [2:0] PH_VALUE = 3'd4;
    localparam logic [2:0] PH_SKIP  = 3'd5;
    localparam logic [2:0] PH_IDLE  = 3'd6;

    logic [2:0]  r_phase, n_phase, cur_phase;
    logic [2:0]  r_sig_idx, n_sig_idx, cur_sig_idx;
    logic [1:0]  r_fcnt, n_fcnt, cur_fcnt;
    logic [31:0] r_len, n_len, cur_len;
    logic [32:0] r_rem, n_rem, cur_rem;
    logic [31:0] r_type, n_type, cur_type;
    logic        r_sig_bad, n_sig_bad, cur_sig_bad;

    logic        main_ev;
    logic [2:0]  main_kind;
    logic [7:0]  main_byte;
    logic        main_end;
    logic        final_ev;
    logic [2:0]  final_kind;
    logic [32:0] rem_dec;
    logic        rem_le_limit;
    logic        rem_le_one;

    // Restart from reset values on the first byte of a file
    always_comb begin
        cur_phase   = i_first_byte ? PH_SIG : r_phase;
        cur_sig_idx = i_first_byte ? 3'd0   : r_sig_idx;
        cur_fcnt    = i_first_byte ? 2'd0   : r_fcnt;
        cur_len     = i_first_byte ? 32'd0  : r_len;
        cur_rem     = i_first_byte ? 33'd0  : r_rem;
        cur_type    = i_first_byte ? 32'd0  : r_type;
        cur_sig_bad = i_first_byte ? 1'b0   : r_sig_bad;
    end

    // Saturating countdown; compare the old count so the compare runs beside the subtract
    assign rem_dec      = cur_rem - {32'd0, (cur_rem != 33'd0)};
    assign rem_le_limit = (cur_rem <= (PTE_CRC_BYTES + 33'd1));
    assign rem_le_one   = (cur_rem <= 33'd1);

    // Classify the byte and advance the parser
    always_comb begin
        n_phase    = cur_phase;
        n_sig_idx  = cur_sig_idx;
        n_fcnt     = cur_fcnt;
        n_len      = cur_len;
        n_rem      = cur_rem;
        n_type     = cur_type;
        n_sig_bad  = cur_sig_bad;
        main_ev    = 1'b0;
        main_kind  = EV_KEY;
        main_byte  = 8'd0;
        main_end   = 1'b0;
        final_ev   = 1'b0;
        final_kind = EV_TRUNC;

        unique case (cur_phase)
            PH_SIG: begin
                if (i_stream_byte != sig_byte(cur_sig_idx)) begin
                    n_sig_bad = 1'b1;
                end
                if (cur_sig_idx == 3'd7) begin
                    if (n_sig_bad) begin
                        main_ev   = 1'b1;
                        main_kind = EV_HDR;
                        n_phase   = PH_IDLE;
                    end else begin
                        n_phase = PH_LEN;
                        n_fcnt  = 2'd0;
                        n_len   = 32'd0;
                    end
                    n_sig_idx = 3'd0;
                end else begin
                    n_sig_idx = cur_sig_idx + 3'd1;
                end
            end
            PH_LEN: begin
                n_len = {cur_len[23:0], i_stream_byte};
                if (cur_fcnt == 2'd3) begin
                    n_fcnt  = 2'd0;
                    n_type  = 32'd0;
                    n_phase = PH_TYPE;
                end else begin
                    n_fcnt = cur_fcnt + 2'd1;
                end
            end
            PH_TYPE: begin
                n_type = {cur_type[23:0], i_stream_byte};
                if (cur_fcnt == 2'd3) begin
                    n_fcnt = 2'd0;
                    n_rem  = {1'b0, cur_len} + PTE_CRC_BYTES;
                    if (n_type == TYPE_IEND) begin
                        main_ev   = 1'b1;
                        main_kind = EV_IEND;
                        n_phase   = PH_IDLE;
                    end else if (n_type == TYPE_TEXT && cur_len != 32'd0) begin
                        n_phase = PH_KEY;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end else begin
                    n_fcnt = cur_fcnt + 2'd1;
                end
            end
            PH_KEY: begin
                n_rem = rem_dec;
                if (rem_le_limit) begin
                    // key ran into the chunk end without a NUL, or the value is empty
                    main_ev   = 1'b1;
                    main_kind = EV_DROP;
                    n_phase   = PH_SKIP;
                end else if (i_stream_byte == 8'd0) begin
                    n_phase = PH_VALUE;
                end else begin
                    main_ev   = 1'b1;
                    main_kind = EV_KEY;
                    main_byte = i_stream_byte;
                end
            end
            PH_VALUE: begin
                n_rem     = rem_dec;
                main_ev   = 1'b1;
                main_kind = EV_VALUE;
                main_byte = i_stream_byte;
                main_end  = rem_le_limit;
                if (rem_le_limit) begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_rem = rem_dec;
                if (rem_le_one) begin
                    n_phase = PH_LEN;
                    n_fcnt  = 2'd0;
                    n_len   = 32'd0;
                end
            end
            default: begin
            end
        endcase

        // End of stream before IEND or an error
        if (i_final_byte && n_phase != PH_IDLE) begin
            final_ev   = 1'b1;
            final_kind = (n_phase == PH_SIG && n_sig_bad) ? EV_HDR : EV_TRUNC;
            n_phase    = PH_IDLE;
        end
    end

    // Pack the byte's results into one queue entry
    always_comb begin
        o_rec.kind1 = final_kind;
        if (main_ev) begin
            o_rec.kind0 = main_kind;
            o_rec.byte0 = main_byte;
            o_rec.end0  = main_end;
            o_rec.two   = final_ev;
        end else begin
            o_rec.kind0 = final_kind;
            o_rec.byte0 = 8'd0;
            o_rec.end0  = 1'b0;
            o_rec.two   = 1'b0;
        end
    end

    assign o_push = i_accept && (main_ev || final_ev);

    // Hold parser state between transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIG;
            r_sig_idx <= 3'd0;
            r_fcnt    <= 2'd0;
            r_len     <= 32'd0;
            r_rem     <= 33'd0;
            r_type    <= 32'd0;
            r_sig_bad <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_sig_idx <= n_sig_idx;
            r_fcnt    <= n_fcnt;
            r_len     <= n_len;
            r_rem     <= n_rem;
            r_type    <= n_type;
            r_sig_bad <= n_sig_bad;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pte_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module pte_queue
    import pte_pkg::*;
#(
    parameter int DEPTH = PTE_QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_evt_rec i_rec,
    input  wire logic     i_pop,
    output logic          o_full,
    output logic          o_empty,
    output t_evt_rec      o_rec
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_evt_rec      r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL);
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue occupancy did not follow a write");
`endif

endmodule

`default_nettype wire

[rtl/core/pte_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module pte_back
    import pte_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  wire t_evt_rec   i_rec,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_event_kind,
    output logic [7:0]      o_payload_byte,
    output logic            o_entry_end,
    output logic            o_run_end
);

    logic       r_valid;
    logic [2:0] r_kind;
    logic [7:0] r_byte;
    logic       r_eend;
    logic       r_rend;
    logic       r_second;
    logic [2:0] r_kind1;
    logic       slot_free;

    assign slot_free = !r_valid || i_ready;
    assign o_pop     = slot_free && !r_second && !i_empty;

    // Control: output valid and pending second result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (slot_free) begin
            if (r_second) begin
                r_valid  <= 1'b1;
                r_second <= 1'b0;
            end else if (!i_empty) begin
                r_valid  <= 1'b1;
                r_second <= i_rec.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload: load the next result when the output slot frees
    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_second) begin
                r_kind <= r_kind1;
                r_byte <= 8'd0;
                r_eend <= 1'b0;
                r_rend <= 1'b1;
            end else if (!i_empty) begin
                r_kind  <= i_rec.kind0;
                r_byte  <= i_rec.byte0;
                r_eend  <= i_rec.end0;
                r_rend  <= !i_rec.two;
                r_kind1 <= i_rec.kind1;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_event_kind   = r_kind;
    assign o_payload_byte = r_byte;
    assign o_entry_end    = r_eend;
    assign o_run_end      = r_rend;

`ifndef SYNTHESIS
    a_second_behind_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_valid && !r_rend))
        else $error("second result pending without a first one on show");
    a_second_is_terminal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_second && i_ready) |=> (r_valid && r_rend
            && (r_kind == EV_HDR || r_kind == EV_TRUNC)))
        else $error("second result is not a closing error");
`endif

endmodule

`default_nettype wire

[rtl/core/png_text_chunk_extractor.sv]
// PNG tEXt extractor: feed the file one byte per transaction (first_byte restarts the
// parser); results come out as key bytes, value bytes (entry_end on the last one),
// dropped-entry, header-error, truncated and IEND events, with run_end on the last
// result of each input byte. The block takes one byte per cycle while its queue is not
// full: the parser decides a byte's results combinationally and writes them as one
// entry into a small queue, from which the output register shows one result per cycle
// while i_ready is high, so a byte with two results (only a final byte can cause two)
// holds the output for both while the queue soaks it up. Key bytes of a dropped entry
// have already gone out and must be discarded downstream; CRCs are skipped unchecked.
`timescale 1ns / 1ps
`default_nettype none

module png_text_chunk_extractor
    import pte_pkg::*;
#(
    parameter int QUEUE_DEPTH = PTE_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_stream_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_final_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_event_kind,
    output logic [7:0]      o_payload_byte,
    output logic            o_entry_end,
    output logic            o_run_end
);

    logic     accept;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;
    t_evt_rec push_rec;
    t_evt_rec head_rec;

    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    pte_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_stream_byte (i_stream_byte),
        .i_first_byte  (i_first_byte),
        .i_final_byte  (i_final_byte),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    pte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rec   (head_rec)
    );

    pte_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_rec          (head_rec),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_kind   (o_event_kind),
        .o_payload_byte (o_payload_byte),
        .o_entry_end    (o_entry_end),
        .o_run_end      (o_run_end)
    );

endmodule

`default_nettype wire
